// ----- hw/rtl/ida_pkg.sv -----
// Shared widths, command codes, error codes and status constants for the identifier allocator.
package ida_pkg;

   // Table geometry.
   localparam int ID_COUNT = 256;
   localparam int FIRST_ID = 1;
   localparam int IDX_W    = $clog2(ID_COUNT);
   localparam int CNT_W    = $clog2(ID_COUNT + 1);

   // Field widths of one beat.
   localparam int CMD_W    = 3;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;
   localparam int ERR_W    = 2;

   // Request commands; codes beyond query behave as a query.
   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC       = 3'd0,
      CMD_PARENT_DONE = 3'd1,
      CMD_EXIT        = 3'd2,
      CMD_RELEASE     = 3'd3,
      CMD_QUERY       = 3'd4
   } cmd_type;

   // Response error codes.
   typedef enum logic [ERR_W-1:0] {
      ERR_OK          = 2'd0,
      ERR_EXHAUSTED   = 2'd1,
      ERR_NOT_CLAIMED = 2'd2
   } err_type;

   // Life status values and the masks that the status commands apply.
   localparam logic [STATUS_W-1:0] STATUS_FREE      = 2'b00;
   localparam logic [STATUS_W-1:0] STATUS_NEW       = 2'b11;
   localparam logic [STATUS_W-1:0] MASK_PARENT_DONE = 2'b01;
   localparam logic [STATUS_W-1:0] MASK_EXIT        = 2'b10;
   localparam logic [STATUS_W-1:0] MASK_RELEASE     = 2'b00;

endpackage

// ----- hw/rtl/ida_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module ida_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; a read at the address being written returns the old data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/id_allocator_with_status.sv -----
// Top level of the identifier allocator with per-identifier life status.
//
// A request beat (req_command, req_target_id) is taken at a rising edge where start is
// high and busy is low. busy is low at all times except while reset is held, so one
// request can be taken every cycle. Each request gives exactly one response beat,
// marked by rsp_valid for a single cycle. The memories are read at the edge that takes
// the request. The next cycle decides, writes both memories and loads the response
// register, from which the response shows for one cycle. Back-to-back requests see
// each other's updates through forwarding of the memory writes.
// One request per cycle outside reset, set by the one write port of each memory.
// The receiver cannot stall responses; every response is taken the cycle it shows.
// Reset clears the status table's valid bits and the free stack count and sets the
// fresh identifier counter to the first identifier at once; no clearing pass is needed
// and the block takes a request in the first cycle after reset is released.
module id_allocator_with_status (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ida_pkg::CMD_W-1:0]    req_command,
   input  logic [ida_pkg::ID_W-1:0]     req_target_id,
   output logic                         rsp_valid,
   output logic [ida_pkg::ID_W-1:0]     rsp_result_id,
   output logic                         rsp_claimed,
   output logic [ida_pkg::STATUS_W-1:0] rsp_new_status,
   output logic [ida_pkg::ERR_W-1:0]    rsp_error_code
);

   import ida_pkg::*;

   // Architectural state.
   logic [CNT_W-1:0]    free_count_ff, free_count_in;
   logic [CNT_W-1:0]    next_fresh_ff, next_fresh_in;
   logic [ID_COUNT-1:0] valid_ff;

   // Read stage registers.
   logic                s1_valid_ff;
   logic [CMD_W-1:0]    s1_cmd_ff;
   logic [ID_W-1:0]     s1_tid_ff;
   logic                s1_vld_rd_ff;
   logic                s1_st_fwd_ff;
   logic [STATUS_W-1:0] s1_st_fwd_data_ff;
   logic                s1_stk_fwd_ff;
   logic [ID_W-1:0]     s1_stk_fwd_data_ff;

   // Response registers.
   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ERR_W-1:0]    rsp_err_ff;
   err_type             rsp_err_in;

   // Memory ports.
   logic                st_we;
   logic [IDX_W-1:0]    st_waddr;
   logic [STATUS_W-1:0] st_wdata;
   logic [STATUS_W-1:0] st_rdata;
   logic                stk_we;
   logic [IDX_W-1:0]    stk_waddr;
   logic [IDX_W-1:0]    stk_raddr;
   logic [ID_W-1:0]     stk_rdata;

   // Decision stage signals.
   logic                accept;
   logic [IDX_W-1:0]    req_idx;
   logic                s1_in_table;
   logic [STATUS_W-1:0] st_eff;
   logic [ID_W-1:0]     stk_eff;
   logic [STATUS_W-1:0] cmd_mask;
   logic [STATUS_W-1:0] masked;

   assign busy    = reset;
   assign accept  = start & ~busy;
   assign req_idx = IDX_W'(req_target_id);

   // Status table and free stack.
   ida_ram #(.WIDTH(STATUS_W), .DEPTH(ID_COUNT)) u_status_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (st_rdata)
   );

   ida_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (s1_tid_ff),
      .rd_en   (accept),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // The top of the stack after the beat in the decision stage is the next pop address.
   assign stk_raddr = IDX_W'(free_count_in - CNT_W'(1));

   // Effective operands: forwarded writes win over the memory read data.
   assign s1_in_table = (32'(s1_tid_ff) < ID_COUNT);
   assign st_eff  = !s1_in_table  ? STATUS_FREE :
                    s1_st_fwd_ff  ? s1_st_fwd_data_ff :
                    s1_vld_rd_ff  ? st_rdata : STATUS_FREE;
   assign stk_eff = s1_stk_fwd_ff ? s1_stk_fwd_data_ff : stk_rdata;

   // Mask applied by each status command.
   always_comb begin
      unique case (s1_cmd_ff)
         CMD_PARENT_DONE: cmd_mask = MASK_PARENT_DONE;
         CMD_EXIT:        cmd_mask = MASK_EXIT;
         default:         cmd_mask = MASK_RELEASE;
      endcase
   end

   assign masked = st_eff & cmd_mask;

   // Decision logic for the beat in the read stage.
   always_comb begin
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      st_we         = 1'b0;
      st_waddr      = IDX_W'(s1_tid_ff);
      st_wdata      = STATUS_NEW;
      stk_we        = 1'b0;
      stk_waddr     = IDX_W'(free_count_ff);
      rsp_id_in     = s1_tid_ff;
      rsp_status_in = st_eff;
      rsp_err_in    = ERR_OK;
      if (s1_valid_ff) begin
         unique case (s1_cmd_ff)
            CMD_ALLOC: begin
               if (free_count_ff != '0) begin
                  free_count_in = free_count_ff - CNT_W'(1);
                  rsp_id_in     = stk_eff;
                  rsp_status_in = STATUS_NEW;
                  st_we         = 1'b1;
                  st_waddr      = IDX_W'(stk_eff);
               end else if (next_fresh_ff < CNT_W'(ID_COUNT)) begin
                  next_fresh_in = next_fresh_ff + CNT_W'(1);
                  rsp_id_in     = ID_W'(next_fresh_ff);
                  rsp_status_in = STATUS_NEW;
                  st_we         = 1'b1;
                  st_waddr      = IDX_W'(next_fresh_ff);
               end else begin
                  rsp_id_in     = '0;
                  rsp_status_in = STATUS_FREE;
                  rsp_err_in    = ERR_EXHAUSTED;
               end
            end
            CMD_PARENT_DONE, CMD_EXIT, CMD_RELEASE: begin
               if (st_eff == STATUS_FREE) begin
                  rsp_status_in = STATUS_FREE;
                  rsp_err_in    = ERR_NOT_CLAIMED;
               end else begin
                  rsp_status_in = masked;
                  st_we         = 1'b1;
                  st_wdata      = masked;
                  if (masked == STATUS_FREE && free_count_ff < CNT_W'(ID_COUNT)) begin
                     stk_we        = 1'b1;
                     free_count_in = free_count_ff + CNT_W'(1);
                  end
               end
            end
            default: begin
               rsp_status_in = st_eff;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         next_fresh_ff <= CNT_W'(FIRST_ID);
         valid_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         if (st_we) begin
            valid_ff[st_waddr] <= 1'b1;
         end
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Read stage payload and forwarding of the writes made in the same cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff          <= req_command;
         s1_tid_ff          <= req_target_id;
         s1_vld_rd_ff       <= valid_ff[req_idx];
         s1_st_fwd_ff       <= st_we && (st_waddr == req_idx);
         s1_st_fwd_data_ff  <= st_wdata;
         s1_stk_fwd_ff      <= stk_we && (stk_waddr == stk_raddr);
         s1_stk_fwd_data_ff <= s1_tid_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_new_status = rsp_status_ff;
   assign rsp_claimed    = (rsp_status_ff != STATUS_FREE);
   assign rsp_error_code = rsp_err_ff;

endmodule
